[sv/first_fit_boundary_tag_allocator_unit_defines.svh]
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_UNIT_DEFINES_SVH

// Assert an implication on the rising clock edge, held off during reset.
`define FFBT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Assert an implication checked on the next clock edge, held off during reset.
`define FFBT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ffbt_pkg.sv]
// -----------------------------------------------------------------------------
// ffbt_pkg
// Shared types, constants and codes of the first-fit boundary-tag allocator.
// -----------------------------------------------------------------------------
`default_nettype none

package ffbt_pkg;

    localparam int HeapBytes = 4096;
    localparam int TagBytes  = 8;
    localparam int AW        = $clog2(HeapBytes);
    // Sums are carried two bits wider so that overruns past the heap show.
    localparam int XW        = AW + 2;
    localparam int SW        = AW + 1;

    localparam logic [XW-1:0] HEAP_X  = XW'(HeapBytes);
    localparam logic [XW-1:0] TAG_X   = XW'(TagBytes);
    localparam logic [XW-1:0] TAG2_X  = XW'(2 * TagBytes);
    localparam logic [SW-1:0] INIT_SZ = SW'(HeapBytes - 2 * TagBytes);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_WASFREE  = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_IWR0, S_IWR1,
        S_ARD, S_AWAIT, S_ACHK, S_AWR0, S_AWR1, S_AWR2, S_AWR3,
        S_FRD, S_FWAIT, S_FCHK, S_FNRD, S_FNWAIT, S_FNCHK,
        S_FPRD, S_FPWAIT, S_FPCHK, S_FWR0, S_FWR1,
        S_OUT
    } state_t;

    // Datapath commands, one per controller state.
    typedef struct packed {
        state_t st;
        logic   load;
        // Set with load when the beat starts an allocate walk at address zero.
        logic   walk;
    } cmd_t;

    typedef struct packed {
        logic req_zero;
        logic walk_end;
        logic fit;
        logic split;
        logic clr_done;
        logic free_bad;
        logic was_free;
        logic pad;
    } sts_t;

endpackage

`default_nettype wire

[sv/first_fit_boundary_tag_allocator_unit.sv]
// -----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_unit
// First-fit heap allocator with boundary tags and coalescing of free blocks.
// -----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)                              tuser
// s_axis    in   operation[1:0], request_size[13:2],            -
//                payload_address[25:14], zeros to 32
// m_axis    out  result_address[11:0], status[13:12], zeros      -
//
// Allocate reads the tag of each block visited on the walk, then makes up to
// four tag writes; the tag memory has a registered read. Free reads its own
// tag, the next block's tag unless the freed block ends at the heap's end, and
// the previous block's tag, then writes two tags. Reinitialise, and reset,
// sweep all 4096 tag entries, one a cycle, before the first item is taken.
// A stalled result holds the block; no new beat is taken until it leaves.
// -----------------------------------------------------------------------------
`default_nettype none

module first_fit_boundary_tag_allocator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // operation[1:0], request_size[13:2], payload_address[25:14]
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result_address[11:0], status[13:12]
    output logic [15:0]      m_axis_tdata
);
    import ffbt_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [11:0] res_addr;
    logic [1:0]  status;

    ffbt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tdata[1:0]),
        .in_addr    (s_axis_tdata[25:14]),
        .sts        (sts),
        .cmd        (cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status)
    );

    ffbt_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_req   (s_axis_tdata[13:2]),
        .in_addr  (s_axis_tdata[25:14]),
        .sts      (sts),
        .res_addr (res_addr)
    );

    // A no-fit status forces a zero result address.
    always_comb begin
        m_axis_tdata = {2'b00, status, res_addr};
        if (status == ST_NOFIT) begin
            m_axis_tdata[11:0] = '0;
        end
    end

endmodule

`default_nettype wire

[sv/ffbt_datapath.sv]
// -----------------------------------------------------------------------------
// ffbt_datapath
// Tag memory, walk pointer and address arithmetic of the allocator.
// -----------------------------------------------------------------------------
`default_nettype none

module ffbt_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ffbt_pkg::cmd_t       cmd,
    input  wire logic [11:0]          in_req,
    input  wire logic [11:0]          in_addr,
    output ffbt_pkg::sts_t            sts,
    output logic [11:0]               res_addr
);
    import ffbt_pkg::*;

    // Tag store: size and occupied mark, one entry per byte address.
    logic [SW:0]    mem [HeapBytes];
    logic [SW:0]    rd_reg;
    logic [AW-1:0]  ra, wa;
    logic           we;
    logic [SW:0]    wd;

    logic [XW-1:0]  req_reg, h_reg, h_next, s_reg, head_reg, tail_reg, cnt_reg;
    logic [XW-1:0]  nh_reg, tmp_reg;
    logic [XW-1:0]  rd_s;
    logic           rd_o;

    assign rd_s = XW'(rd_reg[SW-1:0]);
    assign rd_o = rd_reg[SW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[ra];
    end

    // Read address and write port per state.
    always_comb begin
        ra = h_reg[AW-1:0];
        we = 1'b0;
        wa = '0;
        wd = '0;
        case (cmd.st)
            S_CLR: begin
                we = 1'b1;
                wa = cnt_reg[AW-1:0];
            end
            S_IWR0: begin
                we = 1'b1;
                wd = {1'b0, INIT_SZ};
            end
            S_IWR1: begin
                we = 1'b1;
                wa = AW'(HEAP_X - TAG_X);
                wd = {1'b0, INIT_SZ};
            end
            S_FNRD, S_FNWAIT: ra = nh_reg[AW-1:0];
            S_FPRD, S_FPWAIT: ra = AW'(h_reg - TAG_X);
            S_AWR0: begin
                we = 1'b1;
                wa = AW'(h_reg + TAG2_X + req_reg);
                wd = {1'b0, SW'(tmp_reg)};
            end
            S_AWR1: begin
                we = 1'b1;
                wa = AW'(h_reg + TAG_X + s_reg);
                wd = {1'b0, SW'(tmp_reg)};
            end
            S_AWR2: begin
                we = 1'b1;
                wa = h_reg[AW-1:0];
                wd = {1'b1, SW'(s_reg)};
            end
            S_AWR3: begin
                we = 1'b1;
                wa = AW'(h_reg + TAG_X + s_reg);
                wd = {1'b1, SW'(s_reg)};
            end
            S_FWR0: begin
                we = 1'b1;
                wa = head_reg[AW-1:0];
                wd = {1'b0, SW'(tail_reg - head_reg - TAG_X)};
            end
            S_FWR1: begin
                we = 1'b1;
                wa = tail_reg[AW-1:0];
                wd = {1'b0, SW'(tail_reg - head_reg - TAG_X)};
            end
            default: ;
        endcase
    end

    // Status flags for the controller.
    always_comb begin
        sts          = '0;
        sts.req_zero = (req_reg == '0);
        sts.walk_end = (h_reg >= HEAP_X) || (h_reg + TAG2_X + rd_s > HEAP_X);
        sts.fit      = !rd_o && (rd_s >= req_reg);
        sts.split    = rd_s > req_reg + TAG2_X;
        sts.clr_done = (cnt_reg == HEAP_X - XW'(1));
        sts.free_bad = (h_reg + TAG2_X + rd_s > HEAP_X);
        sts.was_free = !rd_o;
        sts.pad      = (nh_reg < HEAP_X);
    end

    assign h_next = h_reg + TAG2_X + rd_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            req_reg  <= XW'(in_req);
            h_reg    <= cmd.walk ? '0 : XW'(in_addr) - TAG_X;
            cnt_reg  <= '0;
            res_addr <= '0;
        end else begin
            case (cmd.st)
                S_CLR: cnt_reg <= cnt_reg + XW'(1);
                S_ARD: ;
                S_ACHK: begin
                    s_reg   <= rd_s;
                    tmp_reg <= rd_s - req_reg - TAG2_X;
                    if (!sts.walk_end && !sts.fit) begin
                        h_reg <= h_next;
                    end
                    res_addr <= 12'((h_reg + TAG_X) & XW'(12'hFFF));
                end
                S_AWR1: s_reg <= req_reg;
                S_FCHK: begin
                    s_reg    <= rd_s;
                    head_reg <= h_reg;
                    tail_reg <= h_reg + TAG_X + rd_s;
                    nh_reg   <= h_reg + TAG2_X + rd_s;
                    res_addr <= 12'(h_reg);
                end
                S_FNCHK: begin
                    if (!rd_o && (nh_reg + TAG2_X + rd_s <= HEAP_X)) begin
                        tail_reg <= nh_reg + TAG_X + rd_s;
                    end
                end
                S_FPCHK: begin
                    if (!rd_o && (TAG2_X + rd_s <= h_reg)) begin
                        head_reg <= h_reg - TAG2_X - rd_s;
                        res_addr <= 12'(h_reg - TAG2_X - rd_s);
                    end
                end
                S_IWR0: res_addr <= '0;
                default: ;
            endcase
        end
    end

    // The clear counter, the only counter here, for the rules below.
    // (h_reg is loaded on each item; cnt_reg is reset.)

    `include "first_fit_boundary_tag_allocator_unit_defines.svh"

    `FFBT_ASSERT_IMP(a_clr_we, aclk, aresetn, cmd.st == S_CLR, we && wd == '0, "clear pass must write zero")
    `FFBT_ASSERT_NEXT(a_cnt_step, aclk, aresetn, cmd.st == S_CLR && !cmd.load, cnt_reg == $past(cnt_reg) + XW'(1), "clear counter must step")
    `FFBT_ASSERT_IMP(a_idle_nowr, aclk, aresetn, cmd.st == S_IDLE || cmd.st == S_OUT, !we, "no write while idle")

endmodule

`default_nettype wire

[sv/ffbt_ctrl.sv]
// -----------------------------------------------------------------------------
// ffbt_ctrl
// Controller state machine: sequences clear, allocate walk and free merge.
// -----------------------------------------------------------------------------
`default_nettype none

module ffbt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_op,
    input  wire logic [11:0]       in_addr,
    input  wire ffbt_pkg::sts_t    sts,
    output ffbt_pkg::cmd_t         cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             out_status
);
    import ffbt_pkg::*;

    state_t      state_reg, state_next;
    op_t         op_reg;
    logic [1:0]  stat_reg, stat_next;
    logic        bad_p;

    // Payload address below one tag is rejected.
    assign bad_p = (XW'(in_addr) < TAG_X);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            stat_reg  <= ST_OK;
            op_reg    <= OP_NONE;
        end else begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
            if (in_valid && in_ready) begin
                op_reg <= op_t'(in_op);
            end
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        stat_next  = stat_reg;
        cmd.st     = state_reg;
        cmd.load   = 1'b0;
        cmd.walk   = 1'b0;
        in_ready   = (state_reg == S_IDLE);
        out_valid  = (state_reg == S_OUT);
        out_status = stat_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    case (op_t'(in_op))
                        OP_ALLOC: begin
                            cmd.walk   = 1'b1;
                            state_next = S_ARD;
                        end
                        OP_FREE: begin
                            if (bad_p) begin
                                stat_next  = ST_NOFIT;
                                state_next = S_OUT;
                            end else begin
                                state_next = S_FRD;
                            end
                        end
                        OP_INIT: state_next = S_CLR;
                        default: begin
                            stat_next  = ST_NOFIT;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_CLR:  if (sts.clr_done) state_next = S_IWR0;
            S_IWR0: state_next = S_IWR1;
            S_IWR1: begin
                stat_next  = ST_OK;
                state_next = (op_reg == OP_INIT) ? S_OUT : S_IDLE;
            end
            S_ARD: begin
                if (sts.req_zero) begin
                    stat_next  = ST_NOFIT;
                    state_next = S_OUT;
                end else begin
                    state_next = S_AWAIT;
                end
            end
            S_AWAIT: state_next = S_ACHK;
            S_ACHK: begin
                if (sts.walk_end) begin
                    stat_next  = ST_NOFIT;
                    state_next = S_OUT;
                end else if (sts.fit) begin
                    stat_next  = ST_OK;
                    state_next = sts.split ? S_AWR0 : S_AWR2;
                end else begin
                    state_next = S_ARD;
                end
            end
            S_AWR0: state_next = S_AWR1;
            S_AWR1: state_next = S_AWR2;
            S_AWR2: state_next = S_AWR3;
            S_AWR3: state_next = S_OUT;
            S_FRD:   state_next = S_FWAIT;
            S_FWAIT: state_next = S_FCHK;
            S_FCHK: begin
                if (sts.was_free) begin
                    stat_next  = ST_WASFREE;
                    state_next = S_OUT;
                end else if (sts.free_bad) begin
                    stat_next  = ST_NOFIT;
                    state_next = S_OUT;
                end else begin
                    stat_next  = ST_OK;
                    state_next = S_FNRD;
                end
            end
            S_FNRD: begin
                state_next = sts.pad ? S_FNWAIT : S_FPRD;
            end
            S_FNWAIT: state_next = S_FNCHK;
            S_FNCHK:  state_next = S_FPRD;
            S_FPRD:   state_next = S_FPWAIT;
            S_FPWAIT: state_next = S_FPCHK;
            S_FPCHK:  state_next = S_FWR0;
            S_FWR0:   state_next = S_FWR1;
            S_FWR1:   state_next = S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    `include "first_fit_boundary_tag_allocator_unit_defines.svh"

    `FFBT_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid && !out_ready, out_valid && $stable(out_status), "result must hold while stalled")
    `FFBT_ASSERT_IMP(a_excl, aclk, aresetn, in_ready, !out_valid, "accept and result never overlap")
    `FFBT_ASSERT_IMP(a_status, aclk, aresetn, out_valid, out_status != ST_RSVD, "reserved status")

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit boundary-tag allocator. A directed
// table covers reset state, size extremes, bad and already-free addresses,
// reinitialise and the undefined operation; random allocate/free traffic
// follows, checked against a behavioural copy of the heap's tag store.
// -----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import ffbt_pkg::*;

    localparam int HB = 4096;
    localparam int TB = 8;

    typedef struct packed {
        logic [11:0] addr;
        logic [1:0]  st;
    } outcome_t;

    typedef struct {
        op_t         op;
        logic [11:0] req;
        logic [11:0] paddr;
        logic        fixed;
        outcome_t    want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    // Model of the tag store: size and occupied mark per byte address.
    int unsigned heap_size[HB];
    bit          heap_occ[HB];
    outcome_t    pending_results[$];
    logic [11:0] live_blocks[$];
    int          errors = 0;
    bit          hold_long = 1'b0;

    always #5 aclk = ~aclk;

    first_fit_boundary_tag_allocator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic void write_tag(int unsigned at, int unsigned sz, bit occ);
        if (at < HB) begin
            heap_size[at] = sz;
            heap_occ[at] = occ;
        end
    endfunction

    function automatic void rebuild_heap();
        for (int i = 0; i < HB; i++) begin
            heap_size[i] = 0;
            heap_occ[i] = 1'b0;
        end
        write_tag(0, HB - 2 * TB, 1'b0);
        write_tag(HB - TB, HB - 2 * TB, 1'b0);
    endfunction

    // First-fit walk with split; updates the model heap.
    function automatic outcome_t grant_block(int unsigned req);
        outcome_t    r;
        int unsigned h, s, used, rest;
        r.addr = '0;
        r.st = ST_NOFIT;
        if (req == 0) return r;
        h = 0;
        while (h < HB) begin
            s = heap_size[h];
            if (h + 2 * TB + s > HB) return r;
            if (!heap_occ[h] && s >= req) begin
                used = s;
                if (s > req + 2 * TB) begin
                    rest = s - req - 2 * TB;
                    write_tag(h + 2 * TB + req, rest, 1'b0);
                    write_tag(h + TB + s, rest, 1'b0);
                    used = req;
                end
                write_tag(h, used, 1'b1);
                write_tag(h + TB + used, used, 1'b1);
                r.addr = 12'(h + TB);
                r.st = ST_OK;
                return r;
            end
            h += 2 * TB + s;
        end
        return r;
    endfunction

    // Release with coalescing of both neighbours.
    function automatic outcome_t release_block(int unsigned p);
        outcome_t    r;
        int unsigned h, s, head, tail, nh, nt, pt, back, ns;
        r.addr = '0;
        r.st = ST_NOFIT;
        if (p < TB) return r;
        h = p - TB;
        if (!heap_occ[h]) begin
            r.addr = 12'(h);
            r.st = ST_WASFREE;
            return r;
        end
        s = heap_size[h];
        if (h + 2 * TB + s > HB) return r;
        head = h;
        tail = h + TB + s;
        nh = h + 2 * TB + s;
        if (nh < HB && !heap_occ[nh]) begin
            nt = nh + TB + heap_size[nh];
            if (nt + TB <= HB) tail = nt;
        end
        if (h >= TB) begin
            pt = h - TB;
            if (!heap_occ[pt]) begin
                back = 2 * TB + heap_size[pt];
                if (back <= h) head = h - back;
            end
        end
        ns = tail - head - TB;
        write_tag(head, ns, 1'b0);
        write_tag(tail, ns, 1'b0);
        r.addr = 12'(head);
        r.st = ST_OK;
        return r;
    endfunction

    function automatic outcome_t predict_outcome(op_t op, logic [11:0] req,
                                                 logic [11:0] pa);
        outcome_t r;
        r.addr = '0;
        r.st = ST_NOFIT;
        case (op)
            OP_ALLOC: r = grant_block(req);
            OP_FREE:  r = release_block(pa);
            OP_INIT: begin
                rebuild_heap();
                r.st = ST_OK;
            end
            default: r.st = ST_NOFIT;
        endcase
        return r;
    endfunction

    // Send one beat and record its expected outcome at acceptance.
    task automatic send_beat(op_t op, logic [11:0] req, logic [11:0] pa,
                             bit fixed, outcome_t want);
        outcome_t r;
        int       gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
              : $urandom_range(1, 3);
        repeat (gap) @(posedge aclk);
        s_axis_tdata <= {6'd0, pa, req, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        r = predict_outcome(op, req, pa);
        if (fixed && r != want) begin
            $display("%0t table row disagrees: expected %h model %h", $time, want, r);
            errors++;
        end
        if (op == OP_ALLOC && r.st == ST_OK) live_blocks.push_back(r.addr);
        if (op == OP_INIT) live_blocks.delete();
        pending_results.push_back(fixed ? want : r);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        outcome_t got, exp_r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.addr = m_axis_tdata[11:0];
            got.st = m_axis_tdata[13:12];
            if (pending_results.size() == 0) begin
                $display("%0t unexpected beat: actual addr %h status %0d",
                         $time, got.addr, got.st);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.addr !== exp_r.addr)
                    $display("%0t addr mismatch: expected %h actual %h",
                             $time, exp_r.addr, got.addr);
                if (got.st !== exp_r.st)
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, exp_r.st, got.st);
                if (got !== exp_r) errors++;
            end
        end
    end

    // Receiver back-pressure: random stalls, and one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                m_axis_tready <= 1'b0;
                for (n = 0; n < 3000; n++) @(posedge aclk);
                hold_long = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                    : $urandom_range(1, 3);
                repeat (n) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100) : 0;
            repeat (n) @(posedge aclk);
        end
    end

    // Run limit.
    initial begin
        #500ms;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        row_t        table_rows[$];
        row_t        rw;
        outcome_t    none;
        int          pick, idx;
        logic [11:0] req, pa;
        none = '0;
        rebuild_heap();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows: fixed outcomes where plain, otherwise predicted.
        table_rows.push_back('{OP_ALLOC, 12'd0, 12'd0, 1, '{12'd0, ST_NOFIT}});
        table_rows.push_back('{OP_FREE, 12'd0, 12'd8, 1, '{12'd0, ST_WASFREE}});
        table_rows.push_back('{OP_FREE, 12'd0, 12'd3, 1, '{12'd0, ST_NOFIT}});
        table_rows.push_back('{OP_ALLOC, 12'hfff, 12'd0, 1, '{12'd0, ST_NOFIT}});
        table_rows.push_back('{OP_NONE, 12'hfff, 12'hfff, 1, '{12'd0, ST_NOFIT}});
        table_rows.push_back('{OP_ALLOC, 12'd4080, 12'd0, 1, '{12'd8, ST_OK}});
        table_rows.push_back('{OP_ALLOC, 12'd1, 12'd0, 1, '{12'd0, ST_NOFIT}});
        table_rows.push_back('{OP_FREE, 12'd0, 12'd8, 1, '{12'd0, ST_OK}});
        table_rows.push_back('{OP_ALLOC, 12'd1, 12'd0, 1, '{12'd8, ST_OK}});
        table_rows.push_back('{OP_ALLOC, 12'd100, 12'd0, 0, none});
        table_rows.push_back('{OP_ALLOC, 12'd4050, 12'd0, 0, none});
        table_rows.push_back('{OP_ALLOC, 12'd200, 12'd0, 0, none});
        table_rows.push_back('{OP_FREE, 12'd0, 12'd33, 0, none});
        table_rows.push_back('{OP_FREE, 12'd0, 12'd8, 0, none});
        table_rows.push_back('{OP_FREE, 12'd0, 12'hfff, 0, none});
        table_rows.push_back('{OP_FREE, 12'd0, 12'd4088, 0, none});
        table_rows.push_back('{OP_INIT, 12'hfff, 12'hfff, 1, '{12'd0, ST_OK}});
        table_rows.push_back('{OP_ALLOC, 12'd2730, 12'd0, 0, none});
        table_rows.push_back('{OP_ALLOC, 12'd1365, 12'd0, 0, none});
        table_rows.push_back('{OP_FREE, 12'd0, 12'd2754, 0, none});
        table_rows.push_back('{OP_INIT, 12'd0, 12'd0, 1, '{12'd0, ST_OK}});
        foreach (table_rows[i]) begin
            rw = table_rows[i];
            send_beat(rw.op, rw.req, rw.paddr, rw.fixed, rw.want);
        end

        // Random traffic: mostly small allocations and frees of live blocks.
        for (int k = 0; k < 1330; k++) begin
            if (k == 300) hold_long = 1'b1;
            if (k == 700) drain_results();
            pick = $urandom_range(0, 99);
            req = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                  : 12'($urandom_range(0, 160));
            pa = 12'($urandom);
            if (pick < 50) begin
                send_beat(OP_ALLOC, req, pa, 0, none);
            end else if (pick < 88 && live_blocks.size() != 0) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                pa = live_blocks[idx];
                live_blocks.delete(idx);
                send_beat(OP_FREE, req, pa, 0, none);
            end else if (pick < 94) begin
                send_beat(OP_FREE, req, pa, 0, none);
            end else if (pick < 97) begin
                send_beat(OP_INIT, req, pa, 0, none);
            end else begin
                send_beat(OP_NONE, req, pa, 0, none);
            end
        end

        drain_results();
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
